// ----- rtl/core/tun_pkg.sv -----
// Package for the triangle unit-normal block: widths, item types.
// No dependencies; every file of the block imports it.
package tun_pkg;

  localparam int COORD_BITS       = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int OUT_W            = 16;

  // cross product magnitudes are brought below 2^NORM_BITS before the root
  localparam int NORM_BITS  = 30;
  localparam int EDGE_SHIFT = (COORD_BITS > NORM_BITS) ? COORD_BITS - NORM_BITS : 0;
  localparam int EDGE_W     = COORD_BITS + 1 - EDGE_SHIFT;
  localparam int PROD_W     = 2 * EDGE_W;
  localparam int N_W        = PROD_W + 1;
  localparam int MAGX_W     = (N_W > NORM_BITS) ? N_W : NORM_BITS;
  localparam int SHIFT_MAX  = MAGX_W - NORM_BITS;
  localparam int SHIFT_W    = $clog2(SHIFT_MAX + 2);

  localparam int SQ_W   = 2 * NORM_BITS;
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 3;

  localparam int NUM_W = NORM_BITS + NORMAL_FRAC_BITS + 1;
  localparam int Q_W   = NORMAL_FRAC_BITS + 1;
  localparam int DV_W  = ROOT_W + Q_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] az;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] bz;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic                    degenerate;
  } out_item_t;

  // item between front and back: scaled magnitudes, signs, zero flag
  typedef struct packed {
    logic [2:0][NORM_BITS-1:0] mag;
    logic [2:0]                neg;
    logic                      degen;
  } fe_item_t;

endpackage

// ----- rtl/core/tun_front.sv -----
// Front end: edges, cross product, zero check and range scaling, 4 stages.
// Depends on tun_pkg; feeds tun_fifo.
module tun_front import tun_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_item,
  output logic     q_push,
  output fe_item_t q_item,
  input  logic     q_full
);

  logic en;

  logic                     v1_r, v2_r, v3_r, v4_r;
  logic signed [EDGE_W-1:0] e1_r [3];
  logic signed [EDGE_W-1:0] e2_r [3];
  logic signed [EDGE_W-1:0] e1_nxt [3];
  logic signed [EDGE_W-1:0] e2_nxt [3];
  logic signed [PROD_W-1:0] p_r [6];
  logic signed [N_W-1:0]    n_r [3];
  fe_item_t                 f4_r, f4_nxt;

  logic [MAGX_W-1:0]  mag [3];
  logic [MAGX_W-1:0]  mag_or;
  logic [SHIFT_W-1:0] shamt;

  function automatic logic signed [EDGE_W-1:0] edge_of(
    input logic signed [COORD_BITS-1:0] p,
    input logic signed [COORD_BITS-1:0] q
  );
    logic signed [COORD_BITS:0] d;
    logic        [COORD_BITS:0] m;
    logic        [EDGE_W-1:0]   ms;
    d  = (COORD_BITS+1)'(p) - (COORD_BITS+1)'(q);
    m  = d[COORD_BITS] ? -d : d;
    ms = EDGE_W'(m >> EDGE_SHIFT);
    return d[COORD_BITS] ? -ms : ms;
  endfunction

  assign en      = !v4_r || !q_full;
  assign in_full = !en;
  assign q_push  = v4_r && !q_full;
  assign q_item  = f4_r;

  always_comb begin
    e1_nxt[0] = edge_of(in_item.bx, in_item.ax);
    e1_nxt[1] = edge_of(in_item.by_coord, in_item.ay);
    e1_nxt[2] = edge_of(in_item.bz, in_item.az);
    e2_nxt[0] = edge_of(in_item.cx, in_item.ax);
    e2_nxt[1] = edge_of(in_item.cy, in_item.ay);
    e2_nxt[2] = edge_of(in_item.cz, in_item.az);
  end

  // magnitudes, then the shift that brings the largest one below 2^NORM_BITS
  always_comb begin
    mag_or = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = MAGX_W'(n_r[i][N_W-1] ? N_W'(-n_r[i]) : N_W'(n_r[i]));
      mag_or = mag_or | mag[i];
    end
    shamt = '0;
    for (int k = NORM_BITS; k < MAGX_W; k++) begin
      if (mag_or[k]) begin
        shamt = SHIFT_W'(k - NORM_BITS + 1);
      end
    end
    for (int i = 0; i < 3; i++) begin
      f4_nxt.mag[i] = NORM_BITS'(mag[i] >> shamt);
      f4_nxt.neg[i] = n_r[i][N_W-1];
    end
    f4_nxt.degen = (mag_or == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_push;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= e1_nxt[i];
        e2_r[i] <= e2_nxt[i];
      end
      p_r[0] <= PROD_W'(e1_r[1]) * PROD_W'(e2_r[2]);
      p_r[1] <= PROD_W'(e1_r[2]) * PROD_W'(e2_r[1]);
      p_r[2] <= PROD_W'(e1_r[2]) * PROD_W'(e2_r[0]);
      p_r[3] <= PROD_W'(e1_r[0]) * PROD_W'(e2_r[2]);
      p_r[4] <= PROD_W'(e1_r[0]) * PROD_W'(e2_r[1]);
      p_r[5] <= PROD_W'(e1_r[1]) * PROD_W'(e2_r[0]);
      n_r[0] <= N_W'(p_r[0]) - N_W'(p_r[1]);
      n_r[1] <= N_W'(p_r[2]) - N_W'(p_r[3]);
      n_r[2] <= N_W'(p_r[4]) - N_W'(p_r[5]);
      f4_r   <= f4_nxt;
    end
  end

endmodule

// ----- rtl/core/tun_fifo.sv -----
// Short register queue between front and back ends.
// Depends on tun_pkg (fe_item_t, QUEUE_DEPTH).
module tun_fifo import tun_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  fe_item_t push_item,
  output logic     full,
  input  logic     pop,
  output fe_item_t pop_item,
  output logic     empty
);

  logic [QA_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QC_W-1:0] count_r;
  fe_item_t        mem_r [QUEUE_DEPTH];
  logic            do_push, do_pop;

  assign full     = (count_r == QC_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/core/tun_back.sv -----
// Back end: sum of squares, pipelined square root, pipelined divide per
// component, sign and saturation, output register. Depends on tun_pkg.
module tun_back import tun_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  output logic      q_pop,
  input  fe_item_t  q_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic en;

  // pop stage and squares
  logic            v0_r, v1_r;
  fe_item_t        s0_r, s1_r;
  logic [SQ_W-1:0] sq_r [3];

  // root chain: index 0 holds the sum, index ROOT_W the finished root
  logic              rv_r    [ROOT_W+1];
  fe_item_t          rside_r [ROOT_W+1];
  logic [SUM_W-1:0]  rx_r    [ROOT_W+1];
  logic [REM_W-1:0]  rrem_r  [ROOT_W+1];
  logic [ROOT_W-1:0] rroot_r [ROOT_W+1];

  // divide chain: index 0 holds numerators and length
  logic              dv_r    [Q_W+1];
  fe_item_t          dside_r [Q_W+1];
  logic [ROOT_W-1:0] dlen_r  [Q_W+1];
  logic [NUM_W-1:0]  drem_r  [Q_W+1][3];
  logic [Q_W-1:0]    dq_r    [Q_W+1][3];

  logic              out_valid_r;
  out_item_t         out_item_r, out_nxt;
  logic [ROOT_W-1:0] len;

  function automatic logic [OUT_W-1:0] signed_sat(input logic [Q_W-1:0] q, input logic neg);
    localparam logic [31:0] POS_LIM = 32'(2**(OUT_W-1) - 1);
    localparam logic [31:0] NEG_LIM = 32'(2**(OUT_W-1));
    logic [31:0] qe;
    qe = 32'(q);
    if (neg) begin
      return (qe > NEG_LIM) ? NEG_LIM[OUT_W-1:0] : -qe[OUT_W-1:0];
    end
    return (qe > POS_LIM) ? POS_LIM[OUT_W-1:0] : qe[OUT_W-1:0];
  endfunction

  assign en        = !out_valid_r || out_pop;
  assign q_pop     = en && !q_empty;
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r     <= 1'b0;
      v1_r     <= 1'b0;
      rv_r[0]  <= 1'b0;
    end else if (en) begin
      v0_r     <= !q_empty;
      v1_r     <= v0_r;
      rv_r[0]  <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= q_item;
      s1_r <= s0_r;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= SQ_W'(s0_r.mag[i]) * SQ_W'(s0_r.mag[i]);
      end
      rside_r[0] <= s1_r;
      rx_r[0]    <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      rrem_r[0]  <= '0;
      rroot_r[0] <= '0;
    end
  end

  // one root bit per stage, two radicand bits brought down each time
  for (genvar j = 0; j < ROOT_W; j++) begin : g_root
    logic [REM_W-1:0] cand, trial;
    logic             ge;

    always_comb begin
      cand  = {rrem_r[j][REM_W-3:0], rx_r[j][SUM_W-1 -: 2]};
      trial = REM_W'({rroot_r[j], 2'b01});
      ge    = (cand >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_r[j+1] <= 1'b0;
      end else if (en) begin
        rv_r[j+1] <= rv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rside_r[j+1] <= rside_r[j];
        rx_r[j+1]    <= {rx_r[j][SUM_W-3:0], 2'b00};
        rrem_r[j+1]  <= ge ? cand - trial : cand;
        rroot_r[j+1] <= {rroot_r[j][ROOT_W-2:0], ge};
      end
    end
  end

  // rounding numerators; length never zero for a real triangle
  assign len = (rroot_r[ROOT_W] == '0) ? ROOT_W'(1) : rroot_r[ROOT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= rv_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dside_r[0] <= rside_r[ROOT_W];
      dlen_r[0]  <= len;
      for (int i = 0; i < 3; i++) begin
        drem_r[0][i] <= (NUM_W'(rside_r[ROOT_W].mag[i]) << NORMAL_FRAC_BITS)
                        + NUM_W'(len >> 1);
        dq_r[0][i]   <= '0;
      end
    end
  end

  // restoring divide, quotient MSB first, three lanes side by side
  for (genvar k = 0; k < Q_W; k++) begin : g_div
    localparam int B = Q_W - 1 - k;
    logic [DV_W-1:0] dsub;
    logic            ge   [3];

    always_comb begin
      dsub = DV_W'(dlen_r[k]) << B;
      for (int i = 0; i < 3; i++) begin
        ge[i] = (DV_W'(drem_r[k][i]) >= dsub);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dside_r[k+1] <= dside_r[k];
        dlen_r[k+1]  <= dlen_r[k];
        for (int i = 0; i < 3; i++) begin
          drem_r[k+1][i] <= ge[i] ? drem_r[k][i] - dsub[NUM_W-1:0] : drem_r[k][i];
          dq_r[k+1][i]   <= {dq_r[k][i][Q_W-2:0], ge[i]};
        end
      end
    end
  end

  always_comb begin
    out_nxt.normal_x   = signed_sat(dq_r[Q_W][0], dside_r[Q_W].neg[0]);
    out_nxt.normal_y   = signed_sat(dq_r[Q_W][1], dside_r[Q_W].neg[1]);
    out_nxt.normal_z   = signed_sat(dq_r[Q_W][2], dside_r[Q_W].neg[2]);
    out_nxt.degenerate = dside_r[Q_W].degen;
    if (dside_r[Q_W].degen) begin
      out_nxt.normal_x = '0;
      out_nxt.normal_y = '0;
      out_nxt.normal_z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_nxt;
    end
  end

endmodule

// ----- rtl/core/triangle_unit_normal_unit.sv -----
// Top level of the triangle unit-normal block: front end, queue, back end.
// Depends on tun_pkg, tun_front, tun_fifo, tun_back.
//
//   Channel  Ports                        Transfer when
//   input    in_push, in_full, in_item    in_push && !in_full
//   result   out_empty, out_pop, out_item out_pop && !out_empty
//
// One triangle per cycle sustained unless a held result stalls the back end;
// every stage is fully pipelined. The path has 4 front stages, the queue,
// and 51 back stages (31 of them the root chain, 15 the divide chain).
// Synchronous active-low reset clears the valid bits and the queue pointers.
// A held result stalls the back end; the 4-entry queue lets the front end
// keep accepting until it fills with an item waiting, then in_full rises.
module triangle_unit_normal_unit import tun_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic     fq_push, fq_full, bq_pop, bq_empty;
  fe_item_t fq_item, bq_item;

  tun_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_push  (fq_push),
    .q_item  (fq_item),
    .q_full  (fq_full)
  );

  tun_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_item (fq_item),
    .full      (fq_full),
    .pop       (bq_pop),
    .pop_item  (bq_item),
    .empty     (bq_empty)
  );

  tun_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (bq_empty),
    .q_pop     (bq_pop),
    .q_item    (bq_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
